### sv/crpc_pkg.sv
// shared types and constants for the route pair counter
`default_nettype none
package crpc_pkg;

  // default parameter values
  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int CODE_CHARS_DEF    = 3;
  localparam int COUNT_BITS_DEF    = 32;

  // fixed field widths
  localparam int BYTE_W  = 8;
  localparam int COL_W   = 8;
  localparam int EIDX_W  = 8;
  localparam int ECODE_W = 24;
  localparam int OUT_CNT_W = 32;

  localparam logic [COL_W-1:0] ORIGIN_COL_RST = 8'd17;
  localparam logic [COL_W-1:0] DEST_COL_RST   = 8'd18;
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [15:0] CODE_NA = 16'h4E41;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_BYTE = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_LONG     = 2'd3
  } status_e;

  typedef enum logic {
    REG_ORIGIN_COL = 1'b0,
    REG_DEST_COL   = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DIRECT = 2'd2,
    CMD_READ   = 2'd3
  } cmd_kind_e;

  // command from the parser to the executing side
  typedef struct packed {
    cmd_kind_e           kind;
    status_e             status;
    logic [EIDX_W-1:0]   a;
    logic [EIDX_W-1:0]   b;
  } cmd_t;

  typedef enum logic [2:0] {
    B_CLEAR  = 3'd0,
    B_IDLE   = 3'd1,
    B_SEARCH = 3'd2,
    B_COUNT  = 3'd3,
    B_EMIT   = 3'd4
  } back_state_e;

endpackage
`default_nettype wire

### sv/crpc_ram.sv
// generic single write, single registered read memory
`default_nettype none
module crpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/crpc_queue.sv
// short command queue between parser and executing side
`default_nettype none
module crpc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = slot_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and fill update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

### sv/crpc_front.sv
// parser: column registers, per-line field capture and command building
`default_nettype none
module crpc_front #(
  parameter int TABLE_ENTRIES = crpc_pkg::TABLE_ENTRIES_DEF,
  parameter int CODE_CHARS    = crpc_pkg::CODE_CHARS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [crpc_pkg::COL_W-1:0]    cfg_wdata,
  input  wire logic                          accept,
  input  wire logic [1:0]                    op,
  input  wire logic [crpc_pkg::BYTE_W-1:0]   line_byte,
  input  wire logic                          line_end,
  input  wire logic [crpc_pkg::EIDX_W-1:0]   entry_index,
  input  wire logic [crpc_pkg::ECODE_W-1:0]  entry_code,
  input  wire logic [crpc_pkg::EIDX_W-1:0]   row_index,
  input  wire logic [crpc_pkg::EIDX_W-1:0]   col_index,
  output logic                               push,
  output crpc_pkg::cmd_t                     cmd,
  output logic [8*CODE_CHARS-1:0]            code_o,
  output logic [8*CODE_CHARS-1:0]            code_d
);
  import crpc_pkg::*;

  localparam int CODE_W = 8 * CODE_CHARS;
  localparam int LEN_W  = $clog2(CODE_CHARS + 2);

  logic [COL_W-1:0]  ocol_r, dcol_r;
  logic [COL_W-1:0]  cc_r, cc_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CODE_W-1:0] chars_r, chars_nxt;
  logic [CODE_W-1:0] ocode_r, ocode_nxt, dcode_r, dcode_nxt;
  logic [1:0]        found_r, found_nxt;
  status_e           err_r, err_nxt;
  logic              hit_o, hit_d;
  logic [CODE_W-1:0] code_al;

  // column registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocol_r <= ORIGIN_COL_RST;
      dcol_r <= DEST_COL_RST;
    end else if (cfg_we) begin
      unique case (reg_e'(cfg_index))
        REG_ORIGIN_COL: ocol_r <= cfg_wdata;
        REG_DEST_COL:   dcol_r <= cfg_wdata;
        default:        ocol_r <= ocol_r;
      endcase
    end
  end

  // field left aligned to the code width
  assign code_al = chars_r << {(LEN_W)'(CODE_CHARS) - len_r, 3'b000};

  // byte parsing and command building
  always_comb begin
    cc_nxt    = cc_r;
    len_nxt   = len_r;
    chars_nxt = chars_r;
    ocode_nxt = ocode_r;
    dcode_nxt = dcode_r;
    found_nxt = found_r;
    err_nxt   = err_r;
    hit_o     = 1'b0;
    hit_d     = 1'b0;
    push      = 1'b0;
    cmd       = '{kind: CMD_DIRECT, status: ST_OK, a: '0, b: '0};
    code_o    = '0;
    code_d    = '0;
    if (accept) begin
      unique case (op_e'(op))
        OP_LOAD: begin
          if (32'(entry_index) < TABLE_ENTRIES) begin
            push     = 1'b1;
            cmd.kind = CMD_LOAD;
            cmd.a    = entry_index;
            code_o   = CODE_W'(entry_code);
          end
        end
        OP_READ: begin
          push  = 1'b1;
          cmd.a = row_index;
          cmd.b = col_index;
          if (32'(row_index) < TABLE_ENTRIES && 32'(col_index) < TABLE_ENTRIES) begin
            cmd.kind = CMD_READ;
          end else begin
            cmd.kind   = CMD_DIRECT;
            cmd.status = ST_INVALID;
          end
        end
        OP_BYTE: begin
          if (err_r == ST_OK) begin
            if (line_byte != CHAR_COMMA) begin
              if (32'(len_r) < CODE_CHARS) begin
                chars_nxt = CODE_W'({chars_r, line_byte});
              end
              if (32'(len_r) <= CODE_CHARS) begin
                len_nxt = len_r + 1'b1;
              end
            end else begin
              if (cc_r != '1) begin
                cc_nxt = cc_r + 1'b1;
                hit_o  = (cc_nxt == ocol_r);
                hit_d  = (cc_nxt == dcol_r);
              end
              if (hit_o || hit_d) begin
                if (len_r == '0) begin
                  err_nxt = ST_INVALID;
                end else if (32'(len_r) > CODE_CHARS) begin
                  err_nxt = ST_LONG;
                end else if (len_r == LEN_W'(2) && chars_r == CODE_W'(CODE_NA)) begin
                  err_nxt = ST_INVALID;
                end else begin
                  if (hit_o) begin
                    ocode_nxt    = code_al;
                    found_nxt[0] = 1'b1;
                  end
                  if (hit_d) begin
                    dcode_nxt    = code_al;
                    found_nxt[1] = 1'b1;
                  end
                end
              end
              len_nxt   = '0;
              chars_nxt = '0;
            end
          end
          // line end: decide the outcome or hand over for lookup
          if (line_end) begin
            push = 1'b1;
            if (err_nxt == ST_LONG) begin
              cmd.status = ST_LONG;
            end else if (err_nxt != ST_OK || found_nxt != 2'b11) begin
              cmd.status = ST_INVALID;
            end else begin
              cmd.kind = CMD_LOOKUP;
              code_o   = ocode_nxt;
              code_d   = dcode_nxt;
            end
            cc_nxt    = '0;
            len_nxt   = '0;
            chars_nxt = '0;
            found_nxt = '0;
            err_nxt   = ST_OK;
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r    <= '0;
      len_r   <= '0;
      chars_r <= '0;
      ocode_r <= '0;
      dcode_r <= '0;
      found_r <= '0;
      err_r   <= ST_OK;
    end else begin
      cc_r    <= cc_nxt;
      len_r   <= len_nxt;
      chars_r <= chars_nxt;
      ocode_r <= ocode_nxt;
      dcode_r <= dcode_nxt;
      found_r <= found_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/crpc_back.sv
// executing side: clearing pass, table loads, code search, counter update or read and result register
`default_nettype none
module crpc_back #(
  parameter int TABLE_ENTRIES = crpc_pkg::TABLE_ENTRIES_DEF,
  parameter int CODE_CHARS    = crpc_pkg::CODE_CHARS_DEF,
  parameter int COUNT_BITS    = crpc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_empty,
  input  wire crpc_pkg::cmd_t                  q_cmd,
  input  wire logic [8*CODE_CHARS-1:0]         q_code_o,
  input  wire logic [8*CODE_CHARS-1:0]         q_code_d,
  output logic                                 q_pop,
  output logic                                 clearing,
  input  wire logic                            out_pop,
  output logic                                 out_empty,
  output logic [1:0]                           out_status,
  output logic [crpc_pkg::EIDX_W-1:0]          out_origin_index,
  output logic [crpc_pkg::EIDX_W-1:0]          out_dest_index,
  output logic [crpc_pkg::OUT_CNT_W-1:0]       out_count_value
);
  import crpc_pkg::*;

  localparam int CODE_W  = 8 * CODE_CHARS;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int PAIR_AW = 2 * IDX_W;
  localparam int PAIR_DEPTH = 1 << PAIR_AW;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  back_state_e       state_r, state_nxt;
  logic [PAIR_AW-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt, io_r, io_nxt, id_r, id_nxt;
  logic              fo_r, fo_nxt, fd_r, fd_nxt, inc_r, inc_nxt;
  logic [CODE_W-1:0] co_r, co_nxt, cd_r, cd_nxt;
  logic [PAIR_AW-1:0] pa_r, pa_nxt;
  status_e           rs_r, rs_nxt;
  logic [EIDX_W-1:0] ro_r, ro_nxt, rd_r, rd_nxt;
  logic [COUNT_BITS-1:0] rc_r, rc_nxt;
  logic              ov_r, ov_nxt, load_out;
  logic [1:0]        os_r;
  logic [EIDX_W-1:0] oo_r, od_r;
  logic [OUT_CNT_W-1:0] oc_r;

  // memory ports
  logic              tab_we;
  logic [IDX_W-1:0]  tab_waddr, tab_raddr;
  logic [CODE_W-1:0] tab_wdata, tab_rdata;
  logic              cnt_we;
  logic [PAIR_AW-1:0] cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata, cnt_inc;
  logic              hit_o, hit_d, last_k;

  crpc_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_raddr), .rdata(tab_rdata)
  );

  crpc_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIR_DEPTH)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  assign clearing  = (state_r == B_CLEAR);
  assign out_empty = !ov_r;
  assign hit_o     = !fo_r && (tab_rdata == co_r);
  assign hit_d     = !fd_r && (tab_rdata == cd_r);
  assign last_k    = (k_r == IDX_W'(TABLE_ENTRIES - 1));
  assign cnt_inc   = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    k_nxt     = k_r;
    io_nxt    = io_r;
    id_nxt    = id_r;
    fo_nxt    = fo_r;
    fd_nxt    = fd_r;
    inc_nxt   = inc_r;
    co_nxt    = co_r;
    cd_nxt    = cd_r;
    pa_nxt    = pa_r;
    rs_nxt    = rs_r;
    ro_nxt    = ro_r;
    rd_nxt    = rd_r;
    rc_nxt    = rc_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    tab_we    = 1'b0;
    tab_waddr = IDX_W'(q_cmd.a);
    tab_wdata = q_code_o;
    tab_raddr = '0;
    cnt_we    = 1'b0;
    cnt_waddr = pa_r;
    cnt_wdata = cnt_inc;
    cnt_raddr = {IDX_W'(q_cmd.a), IDX_W'(q_cmd.b)};
    unique case (state_r)
      B_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        if (32'(clr_r) < TABLE_ENTRIES) begin
          tab_we    = 1'b1;
          tab_waddr = clr_r[IDX_W-1:0];
          tab_wdata = '0;
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          ro_nxt = q_cmd.a;
          rd_nxt = q_cmd.b;
          rs_nxt = q_cmd.status;
          rc_nxt = '0;
          unique case (q_cmd.kind)
            CMD_LOAD: begin
              tab_we = 1'b1;
            end
            CMD_DIRECT: begin
              state_nxt = B_EMIT;
            end
            CMD_READ: begin
              inc_nxt   = 1'b0;
              pa_nxt    = cnt_raddr;
              state_nxt = B_COUNT;
            end
            CMD_LOOKUP: begin
              co_nxt    = q_code_o;
              cd_nxt    = q_code_d;
              fo_nxt    = 1'b0;
              fd_nxt    = 1'b0;
              io_nxt    = '0;
              id_nxt    = '0;
              k_nxt     = '0;
              state_nxt = B_SEARCH;
            end
            default: state_nxt = B_IDLE;
          endcase
        end
      end
      B_SEARCH: begin
        // data of slot k is present, slot k+1 is being read
        tab_raddr = k_r + 1'b1;
        fo_nxt = fo_r || hit_o;
        fd_nxt = fd_r || hit_d;
        if (hit_o) begin
          io_nxt = k_r;
        end
        if (hit_d) begin
          id_nxt = k_r;
        end
        k_nxt = k_r + 1'b1;
        cnt_raddr = {io_nxt, id_nxt};
        if (last_k || (fo_nxt && fd_nxt)) begin
          ro_nxt = fo_nxt ? EIDX_W'(io_nxt) : '0;
          rd_nxt = fd_nxt ? EIDX_W'(id_nxt) : '0;
          if (fo_nxt && fd_nxt) begin
            inc_nxt   = 1'b1;
            pa_nxt    = cnt_raddr;
            state_nxt = B_COUNT;
          end else begin
            rs_nxt    = ST_NOTFOUND;
            state_nxt = B_EMIT;
          end
        end
      end
      B_COUNT: begin
        if (inc_r) begin
          cnt_we = 1'b1;
          rc_nxt = cnt_inc;
        end else begin
          rc_nxt = cnt_rdata;
        end
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (!ov_r || out_pop) begin
          load_out  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // result register handshake
  always_comb begin
    ov_nxt = ov_r;
    if (out_pop && ov_r) begin
      ov_nxt = 1'b0;
    end
    if (load_out) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    io_r  <= io_nxt;
    id_r  <= id_nxt;
    fo_r  <= fo_nxt;
    fd_r  <= fd_nxt;
    inc_r <= inc_nxt;
    co_r  <= co_nxt;
    cd_r  <= cd_nxt;
    pa_r  <= pa_nxt;
    rs_r  <= rs_nxt;
    ro_r  <= ro_nxt;
    rd_r  <= rd_nxt;
    rc_r  <= rc_nxt;
    if (load_out) begin
      os_r <= rs_r;
      oo_r <= ro_r;
      od_r <= rd_r;
      oc_r <= OUT_CNT_W'(rc_r);
    end
  end

  assign out_status       = os_r;
  assign out_origin_index = oo_r;
  assign out_dest_index   = od_r;
  assign out_count_value  = oc_r;

endmodule
`default_nettype wire

### sv/csv_route_pair_counter.sv
// top level of the csv route pair counter
//
//  channel  | ports                                      | moves on
//  ---------+--------------------------------------------+--------------------
//  input    | in_push, in_full, in_op .. in_col_index    | push && !full
//  result   | out_empty, out_pop, out_status .. count    | pop && !empty
//  config   | cfg_we, cfg_index, cfg_wdata               | cfg_we
//
// line bytes, loads and reads are taken one per cycle while the command queue
// has room; a line end hands its lookup to the code table search, which
// examines one slot per cycle.
// after reset a clearing pass zeroes the counter memory and the code table;
// in_full stays high meanwhile.
// a held result stalls the executing side only; the parser runs on until
// the queue fills.
`default_nettype none
module csv_route_pair_counter #(
  parameter int TABLE_ENTRIES = crpc_pkg::TABLE_ENTRIES_DEF,
  parameter int CODE_CHARS    = crpc_pkg::CODE_CHARS_DEF,
  parameter int COUNT_BITS    = crpc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [crpc_pkg::COL_W-1:0]     cfg_wdata,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [1:0]                     in_op,
  input  wire logic [crpc_pkg::BYTE_W-1:0]    in_line_byte,
  input  wire logic                           in_line_end,
  input  wire logic [crpc_pkg::EIDX_W-1:0]    in_entry_index,
  input  wire logic [crpc_pkg::ECODE_W-1:0]   in_entry_code,
  input  wire logic [crpc_pkg::EIDX_W-1:0]    in_row_index,
  input  wire logic [crpc_pkg::EIDX_W-1:0]    in_col_index,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic [1:0]                          out_status,
  output logic [crpc_pkg::EIDX_W-1:0]         out_origin_index,
  output logic [crpc_pkg::EIDX_W-1:0]         out_dest_index,
  output logic [crpc_pkg::OUT_CNT_W-1:0]      out_count_value
);
  import crpc_pkg::*;

  localparam int CODE_W = 8 * CODE_CHARS;
  localparam int Q_W    = $bits(cmd_t) + 2 * CODE_W;

  logic              accept, f_push, q_full, q_empty, q_pop, clearing;
  cmd_t              f_cmd, q_cmd;
  logic [CODE_W-1:0] f_code_o, f_code_d, q_code_o, q_code_d;
  logic [Q_W-1:0]    q_rdata;

  assign in_full = q_full || clearing;
  assign accept  = in_push && !in_full;

  // parser
  crpc_front #(.TABLE_ENTRIES(TABLE_ENTRIES), .CODE_CHARS(CODE_CHARS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .accept(accept), .op(in_op), .line_byte(in_line_byte), .line_end(in_line_end),
    .entry_index(in_entry_index), .entry_code(in_entry_code),
    .row_index(in_row_index), .col_index(in_col_index),
    .push(f_push), .cmd(f_cmd), .code_o(f_code_o), .code_d(f_code_d)
  );

  // command queue
  crpc_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(f_push), .wdata({f_cmd, f_code_o, f_code_d}),
    .pop(q_pop), .rdata(q_rdata), .full(q_full), .empty(q_empty)
  );

  assign {q_cmd, q_code_o, q_code_d} = q_rdata;

  // executing side
  crpc_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .CODE_CHARS(CODE_CHARS), .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_cmd(q_cmd), .q_code_o(q_code_o), .q_code_d(q_code_d),
    .q_pop(q_pop), .clearing(clearing),
    .out_pop(out_pop), .out_empty(out_empty), .out_status(out_status),
    .out_origin_index(out_origin_index), .out_dest_index(out_dest_index),
    .out_count_value(out_count_value)
  );

endmodule
`default_nettype wire
